// ===== rtl/core/fird_pkg.sv =====
// shared constants and types for the fir decimator
// no dependencies; every other file of the block refers to it by scoped names

package fird_pkg;

  // default sizes, handed to the top-level parameters
  localparam int unsigned MAX_TAPS_DEF    = 256;
  localparam int unsigned MAX_RATIO_DEF   = 16;
  localparam int unsigned SAMPLE_BITS_DEF = 24;
  localparam int unsigned IDX_BITS_DEF    = $clog2(MAX_TAPS_DEF);

  // accumulator keeps the full wrapping sum
  localparam int unsigned ACC_W = 64;

  // configuration registers
  localparam int unsigned ADDR_W    = 3;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned RATIO_W   = 5;
  localparam int unsigned TAPS_W    = 9;
  localparam int unsigned REG_IDX_W = 1;

  localparam logic [REG_IDX_W-1:0] REG_RATIO = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_TAPS  = 1'b1;

  localparam logic [RATIO_W-1:0] RATIO_RST = 5'd1;
  localparam logic [TAPS_W-1:0]  TAPS_RST  = 9'd16;

  // item kinds on the input channel
  localparam logic MODE_COEF   = 1'b0;
  localparam logic MODE_SAMPLE = 1'b1;

  // effective settings, already clamped to the legal range
  typedef struct packed {
    logic [RATIO_W-1:0] ratio;
    logic [TAPS_W-1:0]  taps;
  } cfg_t;

  // commands from the sequencer to the mac unit
  typedef struct packed {
    logic clear;
    logic en;
  } mac_cmd_t;

endpackage

// ===== rtl/core/fird_in_if.sv =====
// input channel of the fir decimator: valid/ready plus one coefficient or sample item
// depends on fird_pkg for default widths

interface fird_in_if #(
  parameter int unsigned SAMPLE_BITS = fird_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned IDX_BITS    = fird_pkg::IDX_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic                          mode;
  logic [IDX_BITS-1:0]           coef_index;
  logic signed [SAMPLE_BITS-1:0] value;
  logic                          block_end;

  modport source (output valid, mode, coef_index, value, block_end, input ready);
  modport sink   (input valid, mode, coef_index, value, block_end, output ready);
endinterface

// ===== rtl/core/fird_out_if.sv =====
// output channel of the fir decimator: valid/ready plus one decimated sample
// depends on fird_pkg for default widths

interface fird_out_if #(
  parameter int unsigned SAMPLE_BITS = fird_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;
  logic                          block_end_out;

  modport source (output valid, sample_out, block_end_out, input ready);
  modport sink   (input valid, sample_out, block_end_out, output ready);
endinterface

// ===== rtl/core/fird_regs.sv =====
// apb register file of the fir decimator: ratio and taps_in_use
// depends on fird_pkg; hands clamped settings to the sequencer

module fird_regs #(
  parameter int unsigned MAX_TAPS  = fird_pkg::MAX_TAPS_DEF,
  parameter int unsigned MAX_RATIO = fird_pkg::MAX_RATIO_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [fird_pkg::ADDR_W-1:0] paddr,
  input  logic [fird_pkg::DATA_W-1:0] pwdata,
  output logic [fird_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output fird_pkg::cfg_t              cfg_o
);

  logic [fird_pkg::RATIO_W-1:0] ratio_q, ratio_d;
  logic [fird_pkg::TAPS_W-1:0]  taps_q, taps_d;
  logic [fird_pkg::REG_IDX_W-1:0] reg_idx;
  logic wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2 +: fird_pkg::REG_IDX_W];
  assign wr_en   = psel & penable & pwrite;

  always_comb begin
    ratio_d = ratio_q;
    taps_d  = taps_q;
    prdata  = '0;
    unique case (reg_idx)
      fird_pkg::REG_RATIO: begin
        prdata = fird_pkg::DATA_W'(ratio_q);
        if (wr_en) ratio_d = pwdata[fird_pkg::RATIO_W-1:0];
      end
      fird_pkg::REG_TAPS: begin
        prdata = fird_pkg::DATA_W'(taps_q);
        if (wr_en) taps_d = pwdata[fird_pkg::TAPS_W-1:0];
      end
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ratio_q <= fird_pkg::RATIO_RST;
      taps_q  <= fird_pkg::TAPS_RST;
    end else begin
      ratio_q <= ratio_d;
      taps_q  <= taps_d;
    end
  end

  // zero counts as one, large values clamp to the build limits
  always_comb begin
    if (ratio_q == '0) begin
      cfg_o.ratio = fird_pkg::RATIO_W'(1);
    end else if (int'(ratio_q) > int'(MAX_RATIO)) begin
      cfg_o.ratio = fird_pkg::RATIO_W'(MAX_RATIO);
    end else begin
      cfg_o.ratio = ratio_q;
    end
    if (taps_q == '0) begin
      cfg_o.taps = fird_pkg::TAPS_W'(1);
    end else if (int'(taps_q) > int'(MAX_TAPS)) begin
      cfg_o.taps = fird_pkg::TAPS_W'(MAX_TAPS);
    end else begin
      cfg_o.taps = taps_q;
    end
  end

endmodule

// ===== rtl/core/fird_mac.sv =====
// shared multiply-accumulate unit with round-half-up and saturation of the sum
// depends on fird_pkg for the accumulator width and the command struct

module fird_mac #(
  parameter int unsigned SAMPLE_BITS = fird_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  fird_pkg::mac_cmd_t            cmd_i,
  input  logic signed [SAMPLE_BITS-1:0] coef_i,
  input  logic signed [SAMPLE_BITS-1:0] smp_i,
  output logic                          busy_o,
  output logic signed [SAMPLE_BITS-1:0] result_o
);

  localparam int unsigned ProdW = 2 * SAMPLE_BITS;
  localparam int unsigned Frac  = SAMPLE_BITS - 1;
  localparam int unsigned AccW  = fird_pkg::ACC_W;
  localparam logic signed [AccW-1:0] SatHi = (AccW'(1) << Frac) - AccW'(1);
  localparam logic signed [AccW-1:0] SatLo = ~SatHi;
  localparam logic [AccW-1:0] Half = AccW'(1) << (Frac - 1);

  logic signed [ProdW-1:0] prod_q;
  logic                    prod_vld_q;
  logic signed [AccW-1:0]  acc_q;
  logic [AccW-1:0]         rnd;
  logic signed [AccW-1:0]  shifted;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
    end else begin
      prod_vld_q <= cmd_i.en;
    end
  end

  // product register, then a wrapping 64-bit accumulate
  always_ff @(posedge clk_i) begin
    if (cmd_i.en) prod_q <= coef_i * smp_i;
    if (cmd_i.clear) begin
      acc_q <= '0;
    end else if (prod_vld_q) begin
      acc_q <= acc_q + {{(AccW - ProdW){prod_q[ProdW-1]}}, prod_q};
    end
  end

  assign busy_o  = prod_vld_q;
  assign rnd     = acc_q + Half;
  assign shifted = $signed(rnd) >>> Frac;

  always_comb begin
    if (shifted > SatHi) begin
      result_o = SatHi[SAMPLE_BITS-1:0];
    end else if (shifted < SatLo) begin
      result_o = SatLo[SAMPLE_BITS-1:0];
    end else begin
      result_o = shifted[SAMPLE_BITS-1:0];
    end
  end

endmodule

// ===== rtl/core/fird_ctrl.sv =====
// sequencer of the fir decimator: coefficient and delay memories, tap sweep,
// output register; depends on fird_pkg, fird_in_if, fird_out_if and drives fird_mac

module fird_ctrl #(
  parameter int unsigned MAX_TAPS    = fird_pkg::MAX_TAPS_DEF,
  parameter int unsigned MAX_RATIO   = fird_pkg::MAX_RATIO_DEF,
  parameter int unsigned SAMPLE_BITS = fird_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  fird_pkg::cfg_t                cfg_i,
  fird_in_if.sink                       in_i,
  fird_out_if.source                    out_o,
  output fird_pkg::mac_cmd_t            mac_cmd_o,
  output logic signed [SAMPLE_BITS-1:0] mac_coef_o,
  output logic signed [SAMPLE_BITS-1:0] mac_smp_o,
  input  logic                          mac_busy_i,
  input  logic signed [SAMPLE_BITS-1:0] mac_result_i
);

  localparam int unsigned TapBits = $clog2(MAX_TAPS);
  localparam int unsigned PhBits  = (MAX_RATIO > 1) ? $clog2(MAX_RATIO) : 1;
  localparam int unsigned Cw = ((TapBits > fird_pkg::TAPS_W) ? TapBits : fird_pkg::TAPS_W) + 1;
  localparam int unsigned Pw = ((PhBits > fird_pkg::RATIO_W) ? PhBits : fird_pkg::RATIO_W) + 1;
  localparam logic [TapBits-1:0] LastEntry = TapBits'(MAX_TAPS - 1);

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_RUN   = 5'b00100,
    ST_DRAIN = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic signed [SAMPLE_BITS-1:0] coef_mem [MAX_TAPS];
  logic signed [SAMPLE_BITS-1:0] dly_mem  [MAX_TAPS];

  logic [TapBits-1:0] wpos_q, wpos_d;
  logic [PhBits-1:0]  phase_q, phase_d;
  logic [TapBits-1:0] clr_q, clr_d;
  logic [TapBits-1:0] tap_q, tap_d;
  logic [TapBits-1:0] ptr_q, ptr_d;
  logic               rd_vld_q;
  logic               be_q, be_d;
  logic               out_vld_q, out_vld_d;
  logic signed [SAMPLE_BITS-1:0] res_q, res_d;
  logic signed [SAMPLE_BITS-1:0] out_smp_q;
  logic               out_be_q;
  logic               out_load;

  logic               accept, is_sample, pass;
  logic [Cw-1:0]      n_ext;
  logic [TapBits-1:0] wp_base, wp_next, ptr_next;
  logic [Cw-1:0]      wp_inc, ptr_inc;
  logic [Pw-1:0]      phase_inc;
  logic               fire;
  logic               coef_we, dly_we;
  logic [TapBits-1:0] coef_waddr;
  logic [TapBits-1:0] dly_waddr;
  logic signed [SAMPLE_BITS-1:0] dly_wdata;

  assign in_i.ready = (state_q == ST_IDLE);
  assign accept     = in_i.valid & in_i.ready;
  assign is_sample  = (in_i.mode == fird_pkg::MODE_SAMPLE);
  assign pass       = (cfg_i.ratio == fird_pkg::RATIO_W'(1));
  assign n_ext      = Cw'(cfg_i.taps);

  // write position wraps at the kernel length, also after the length shrank
  assign wp_base   = (Cw'(wpos_q) >= n_ext) ? '0 : wpos_q;
  assign wp_inc    = Cw'(wp_base) + Cw'(1);
  assign wp_next   = (wp_inc >= n_ext) ? '0 : wp_inc[TapBits-1:0];
  assign ptr_inc   = Cw'(ptr_q) + Cw'(1);
  assign ptr_next  = (ptr_inc >= n_ext) ? '0 : ptr_inc[TapBits-1:0];
  assign phase_inc = Pw'(phase_q) + Pw'(1);
  assign fire      = (phase_inc >= Pw'(cfg_i.ratio));

  assign coef_we = accept & ~is_sample & (int'(in_i.coef_index) < int'(MAX_TAPS));
  assign coef_waddr = TapBits'(in_i.coef_index);
  assign dly_we  = (state_q == ST_CLEAR) | (accept & is_sample & ~pass);
  assign dly_waddr = (state_q == ST_CLEAR) ? clr_q : wp_base;
  assign dly_wdata = (state_q == ST_CLEAR) ? '0 : in_i.value;

  assign out_load = (state_q == ST_EMIT) & (~out_vld_q | out_o.ready);

  always_comb begin
    state_d   = state_q;
    wpos_d    = wpos_q;
    phase_d   = phase_q;
    clr_d     = clr_q;
    tap_d     = tap_q;
    ptr_d     = ptr_q;
    be_d      = be_q;
    res_d     = res_q;
    mac_cmd_o = '0;
    out_vld_d = out_vld_q & ~out_o.ready;
    unique case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + TapBits'(1);
        if (clr_q == LastEntry) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept && is_sample) begin
          be_d = in_i.block_end;
          if (pass) begin
            res_d   = in_i.value;
            state_d = ST_EMIT;
          end else begin
            wpos_d = wp_next;
            if (fire) begin
              phase_d         = '0;
              tap_d           = '0;
              ptr_d           = wp_next;
              mac_cmd_o.clear = 1'b1;
              state_d         = ST_RUN;
            end else begin
              phase_d = phase_inc[PhBits-1:0];
            end
          end
        end
      end
      ST_RUN: begin
        // one tap per cycle, oldest sample meets coefficient 0
        tap_d = tap_q + TapBits'(1);
        ptr_d = ptr_next;
        if (Cw'(tap_q) == n_ext - Cw'(1)) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!rd_vld_q && !mac_busy_i) begin
          res_d   = mac_result_i;
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_load) begin
          out_vld_d = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    mac_cmd_o.en = rd_vld_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      wpos_q    <= '0;
      phase_q   <= '0;
      clr_q     <= '0;
      tap_q     <= '0;
      ptr_q     <= '0;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      wpos_q    <= wpos_d;
      phase_q   <= phase_d;
      clr_q     <= clr_d;
      tap_q     <= tap_d;
      ptr_q     <= ptr_d;
      rd_vld_q  <= (state_q == ST_RUN);
      out_vld_q <= out_vld_d;
    end
  end

  // payload registers and memories
  always_ff @(posedge clk_i) begin
    be_q  <= be_d;
    res_q <= res_d;
    if (out_load) begin
      out_smp_q <= res_q;
      out_be_q  <= be_q;
    end
    if (coef_we) coef_mem[coef_waddr] <= in_i.value;
    if (dly_we) dly_mem[dly_waddr] <= dly_wdata;
    if (state_q == ST_RUN) begin
      mac_coef_o <= coef_mem[tap_q];
      mac_smp_o  <= dly_mem[ptr_q];
    end
  end

  assign out_o.valid         = out_vld_q;
  assign out_o.sample_out    = out_smp_q;
  assign out_o.block_end_out = out_be_q;

endmodule

// ===== rtl/core/fir_decimator.sv =====
// fir decimator by an integer ratio, one shared multiply-accumulate unit
// depends on fird_pkg, fird_in_if, fird_out_if, fird_regs, fird_mac, fird_ctrl
//
// usage: the in_i channel carries coefficient items (mode 0, written to slot
// coef_index) and sample items (mode 1). every ratio-th sample triggers one
// output on out_o: the dot product of the coefficients with the last
// taps_in_use samples, oldest first, rounded half up and saturated.
// a ratio of 1 returns each sample unchanged. ratio and taps_in_use sit on
// the apb port at byte addresses 0 and 4; write them only while idle.
// timing: a coefficient item or a sample that completes no output leaves
// in_i ready for the next item; a passthrough sample goes through the emit
// state. for a sample that completes an output the sequencer feeds the mac
// unit one tap per cycle over n = taps_in_use taps, waits for the mac unit
// to drain and then loads the output; in_i is not ready again before the
// output is valid. after reset the delay line is cleared one entry a cycle,
// and in_i stays not ready until every entry is cleared, while configuration
// writes are taken. the output register lets the next item in while a result
// waits; a second result is held until out_o takes the first.

module fir_decimator #(
  parameter int unsigned MAX_TAPS    = fird_pkg::MAX_TAPS_DEF,
  parameter int unsigned MAX_RATIO   = fird_pkg::MAX_RATIO_DEF,
  parameter int unsigned SAMPLE_BITS = fird_pkg::SAMPLE_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [fird_pkg::ADDR_W-1:0] paddr,
  input  logic [fird_pkg::DATA_W-1:0] pwdata,
  output logic [fird_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  fird_in_if.sink                     in_i,
  fird_out_if.source                  out_o
);

  fird_pkg::cfg_t                cfg;
  fird_pkg::mac_cmd_t            mac_cmd;
  logic signed [SAMPLE_BITS-1:0] mac_coef;
  logic signed [SAMPLE_BITS-1:0] mac_smp;
  logic                          mac_busy;
  logic signed [SAMPLE_BITS-1:0] mac_result;

  fird_regs #(
    .MAX_TAPS  (MAX_TAPS),
    .MAX_RATIO (MAX_RATIO)
  ) u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  fird_mac #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (mac_cmd),
    .coef_i   (mac_coef),
    .smp_i    (mac_smp),
    .busy_o   (mac_busy),
    .result_o (mac_result)
  );

  fird_ctrl #(
    .MAX_TAPS    (MAX_TAPS),
    .MAX_RATIO   (MAX_RATIO),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .in_i         (in_i),
    .out_o        (out_o),
    .mac_cmd_o    (mac_cmd),
    .mac_coef_o   (mac_coef),
    .mac_smp_o    (mac_smp),
    .mac_busy_i   (mac_busy),
    .mac_result_i (mac_result)
  );

endmodule

// ===== tb/sv/testbench.sv =====
// testbench for fir_decimator: coefficient loads, sample traffic and register settings
// depends on fird_pkg, fird_in_if, fird_out_if and the fir_decimator rtl

module testbench;

  localparam int unsigned SB          = fird_pkg::SAMPLE_BITS_DEF;
  localparam longint      CYCLE_LIMIT = 2_000_000;
  localparam int unsigned LONG_HOLD   = 2000;
  localparam int unsigned PHASE_ITEMS = 85;

  typedef logic signed [SB-1:0] smp_t;
  typedef struct packed {
    smp_t out_val;
    logic block_end;
  } dec_out_t;

  localparam smp_t S_MIN  = {1'b1, {(SB-1){1'b0}}};
  localparam smp_t S_MAX  = {1'b0, {(SB-1){1'b1}}};
  localparam smp_t S_HALF = {2'b01, {(SB-2){1'b0}}};

  class decim_tracker;
    smp_t                         history [fird_pkg::MAX_TAPS_DEF];
    smp_t                         coefs [fird_pkg::MAX_TAPS_DEF];
    int unsigned                  wr_pos;
    int unsigned                  phase;
    logic [fird_pkg::RATIO_W-1:0] ratio_reg;
    logic [fird_pkg::TAPS_W-1:0]  taps_reg;
    dec_out_t                     due_samples [$];
    int unsigned                  errors;
    int unsigned                  items_taken;
    int unsigned                  outputs_checked;

    function new();
      foreach (history[i]) history[i] = '0;
      foreach (coefs[i]) coefs[i] = '0;
      wr_pos = 0;
      phase = 0;
      ratio_reg = fird_pkg::RATIO_RST;
      taps_reg = fird_pkg::TAPS_RST;
      errors = 0;
      items_taken = 0;
      outputs_checked = 0;
    endfunction

    function void set_reg(logic [fird_pkg::REG_IDX_W-1:0] idx,
                          logic [fird_pkg::DATA_W-1:0] data);
      if (idx == fird_pkg::REG_RATIO) begin
        ratio_reg = data[fird_pkg::RATIO_W-1:0];
      end else if (idx == fird_pkg::REG_TAPS) begin
        taps_reg = data[fird_pkg::TAPS_W-1:0];
      end
    endfunction

    function int unsigned pending();
      return due_samples.size();
    endfunction

    // round half up, then clamp to the sample range
    function smp_t round_sat(longint acc);
      longint t;
      t = (acc + (longint'(1) <<< (SB-2))) >>> (SB-1);
      if (t > longint'(S_MAX)) return S_MAX;
      if (t < longint'(S_MIN)) return S_MIN;
      return smp_t'(t);
    endfunction

    function void note_item(logic mode, logic [fird_pkg::IDX_BITS_DEF-1:0] idx, smp_t v,
                            logic be);
      int unsigned r;
      int unsigned n;
      int unsigned p;
      int unsigned j;
      longint      acc;
      items_taken++;
      if (mode == fird_pkg::MODE_COEF) begin
        coefs[idx] = v;
        return;
      end
      r = (ratio_reg == 0) ? 1 :
          (ratio_reg > fird_pkg::MAX_RATIO_DEF) ? fird_pkg::MAX_RATIO_DEF : ratio_reg;
      n = (taps_reg == 0) ? 1 :
          (taps_reg > fird_pkg::MAX_TAPS_DEF) ? fird_pkg::MAX_TAPS_DEF : taps_reg;
      if (r == 1) begin
        due_samples.push_back('{v, be});
        return;
      end
      // position may be stale after a shorter kernel was set
      if (wr_pos >= n) wr_pos = 0;
      history[wr_pos] = v;
      wr_pos++;
      if (wr_pos >= n) wr_pos = 0;
      if (phase + 1 < r) begin
        phase++;
        return;
      end
      phase = 0;
      p = wr_pos;
      acc = 0;
      // oldest sample meets coefficient 0
      for (j = 0; j < n; j++) begin
        acc += longint'(coefs[j]) * longint'(history[p]);
        p++;
        if (p >= n) p = 0;
      end
      due_samples.push_back('{round_sat(acc), be});
    endfunction

    function void check_output(smp_t got_val, logic got_be);
      dec_out_t want;
      outputs_checked++;
      if (due_samples.size() == 0) begin
        $error("unexpected output transfer: sample_out %0d block_end_out %0b", got_val, got_be);
        errors++;
        return;
      end
      want = due_samples.pop_front();
      if (got_val !== want.out_val) begin
        $error("sample_out: expected %0d, got %0d", want.out_val, got_val);
        errors++;
      end
      if (got_be !== want.block_end) begin
        $error("block_end_out: expected %0b, got %0b", want.block_end, got_be);
        errors++;
      end
    endfunction
  endclass

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [fird_pkg::ADDR_W-1:0]   paddr;
  logic [fird_pkg::DATA_W-1:0]   pwdata;
  logic [fird_pkg::DATA_W-1:0]   prdata;
  logic                          pready;

  fird_in_if  in_ch ();
  fird_out_if out_ch ();

  fir_decimator uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_i    (in_ch),
    .out_o   (out_ch)
  );

  decim_tracker tracker;
  bit           idle_on = 1'b1;
  bit           long_hold_req = 1'b0;
  longint       cycle_count = 0;
  int unsigned  settings_tried = 0;

  always #6 clk_i = ~clk_i;

  function automatic int unsigned pick_gap();
    int unsigned k;
    if (!idle_on) return 0;
    k = $urandom_range(0, 99);
    if (k < 65) return 0;
    if (k < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic smp_t pick_value();
    case ($urandom_range(0, 11))
      0: return S_MIN;
      1: return S_MAX;
      2: return '0;
      3: return '1;
      default: return smp_t'($urandom);
    endcase
  endfunction

  task automatic send_item(logic mode, logic [fird_pkg::IDX_BITS_DEF-1:0] idx, smp_t v,
                           logic be);
    int unsigned gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap != 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid      = 1'b1;
    in_ch.mode       = mode;
    in_ch.coef_index = idx;
    in_ch.value      = v;
    in_ch.block_end  = be;
    do @(posedge clk_i); while (!in_ch.ready);
    tracker.note_item(mode, idx, v, be);
  endtask

  task automatic send_random_item();
    logic mode;
    mode = ($urandom_range(0, 99) < 12) ? fird_pkg::MODE_COEF : fird_pkg::MODE_SAMPLE;
    send_item(mode, fird_pkg::IDX_BITS_DEF'($urandom_range(0, fird_pkg::MAX_TAPS_DEF-1)),
              pick_value(), $urandom_range(0, 7) == 0);
  endtask

  task automatic reg_write(logic [fird_pkg::REG_IDX_W-1:0] idx,
                           logic [fird_pkg::DATA_W-1:0] data);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = data;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    tracker.set_reg(idx, data);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // drain all outputs, then allow for a sweep that produces nothing
  task automatic settle();
    @(negedge clk_i);
    in_ch.valid = 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (fird_pkg::MAX_TAPS_DEF + 16) @(posedge clk_i);
  endtask

  task automatic run_phase(int unsigned ratio_val, int unsigned taps_val, bit squeeze);
    settle();
    reg_write(fird_pkg::REG_RATIO, fird_pkg::DATA_W'(ratio_val));
    reg_write(fird_pkg::REG_TAPS, fird_pkg::DATA_W'(taps_val));
    settings_tried++;
    idle_on = ($urandom_range(0, 3) != 0);
    if (squeeze) begin
      idle_on = 1'b0;
      long_hold_req = 1'b1;
    end
    repeat (PHASE_ITEMS) send_random_item();
  endtask

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("== FAIL ==");
    $finish;
  end

  // output side: random back-pressure, one long hold on request
  initial begin
    int unsigned stall;
    out_ch.ready = 1'b0;
    stall = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        stall = LONG_HOLD;
        long_hold_req = 1'b0;
      end
      if (stall != 0) begin
        out_ch.ready = 1'b0;
        stall--;
      end else begin
        out_ch.ready = 1'b1;
        if ($urandom_range(0, 3) == 0) stall = pick_gap();
      end
      @(posedge clk_i);
      if (out_ch.valid && out_ch.ready) begin
        tracker.check_output(out_ch.sample_out, out_ch.block_end_out);
      end
    end
  end

  initial begin
    int unsigned ph_ratio [14];
    int unsigned ph_taps  [14];
    int unsigned r;
    int unsigned i;
    ph_ratio = '{2, 3, 4, 16, 31, 0, 1, 5, 8, 17, 2, 6, 16, 1};
    ph_taps  = '{8, 12, 16, 256, 511, 0, 16, 7, 1, 300, 256, 24, 16, 256};
    tracker = new();
    rst_ni           = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    in_ch.valid      = 1'b0;
    in_ch.mode       = fird_pkg::MODE_COEF;
    in_ch.coef_index = '0;
    in_ch.value      = '0;
    in_ch.block_end  = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // every slot gets a coefficient before any sum reads it
    for (i = 0; i < fird_pkg::MAX_TAPS_DEF; i++) begin
      send_item(fird_pkg::MODE_COEF, fird_pkg::IDX_BITS_DEF'(i), pick_value(), 1'b0);
    end

    // passthrough at the reset ratio
    send_item(fird_pkg::MODE_SAMPLE, 8'd0, S_MIN, 1'b1);
    send_item(fird_pkg::MODE_SAMPLE, 8'd0, S_MAX, 1'b0);
    send_item(fird_pkg::MODE_SAMPLE, 8'd0, '0, 1'b1);
    send_item(fird_pkg::MODE_SAMPLE, 8'd0, '1, 1'b0);

    settle();
    reg_write(fird_pkg::REG_RATIO, fird_pkg::DATA_W'(2));
    reg_write(fird_pkg::REG_TAPS, fird_pkg::DATA_W'(2));
    settings_tried++;
    // full-scale products saturate both ways
    send_item(fird_pkg::MODE_COEF, 8'd0, S_MIN, 1'b0);
    send_item(fird_pkg::MODE_COEF, 8'd1, S_MIN, 1'b0);
    send_item(fird_pkg::MODE_SAMPLE, 8'd0, S_MIN, 1'b0);
    send_item(fird_pkg::MODE_SAMPLE, 8'd0, S_MIN, 1'b1);
    send_item(fird_pkg::MODE_SAMPLE, 8'd0, S_MAX, 1'b1);
    send_item(fird_pkg::MODE_SAMPLE, 8'd0, S_MAX, 1'b0);
    // half an lsb rounds up, minus half rounds to zero
    send_item(fird_pkg::MODE_COEF, 8'd0, S_HALF, 1'b0);
    send_item(fird_pkg::MODE_COEF, 8'd1, '0, 1'b0);
    send_item(fird_pkg::MODE_SAMPLE, 8'd0, smp_t'(1), 1'b0);
    send_item(fird_pkg::MODE_SAMPLE, 8'd0, '0, 1'b1);
    send_item(fird_pkg::MODE_SAMPLE, 8'd0, '1, 1'b0);
    send_item(fird_pkg::MODE_SAMPLE, 8'd0, '0, 1'b0);

    for (i = 0; i < 14; i++) begin
      run_phase(ph_ratio[i], ph_taps[i], i == 1);
    end
    repeat (6) begin
      r = $urandom_range(1, fird_pkg::MAX_RATIO_DEF);
      run_phase(r, r * $urandom_range(1, fird_pkg::MAX_TAPS_DEF / r), 1'b0);
    end

    settle();
    $display("%0d register settings, %0d input items, %0d output transfers checked",
             settings_tried, tracker.items_taken, tracker.outputs_checked);
    $display("%0d mismatches, %0d outputs still outstanding", tracker.errors, tracker.pending());
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/fird_pkg.sv
rtl/core/fird_in_if.sv
rtl/core/fird_out_if.sv
rtl/core/fird_regs.sv
rtl/core/fird_mac.sv
rtl/core/fird_ctrl.sv
rtl/core/fir_decimator.sv
tb/sv/testbench.sv
